[sv/cll_pkg.sv]
// Shared types, codes and widths for the circular linked list manager.
// No dependencies; compiled first.
package cll_pkg;

    localparam int DEF_POOL_SIZE  = 16;
    localparam int DEF_VALUE_BITS = 32;

    // Fixed field widths of the request and result transfers
    localparam int CMD_W    = 2;
    localparam int DATA_W   = 32;
    localparam int HANDLE_W = 4;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic [CMD_W-1:0] CMD_PREPEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ERASE   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_HANDLE = 2'd2;

    // Datapath operations issued by the controller
    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_NONE       = 5'd0;
    localparam logic [OP_W-1:0] OP_CLEAR      = 5'd1;
    localparam logic [OP_W-1:0] OP_LOAD       = 5'd2;
    localparam logic [OP_W-1:0] OP_SCAN_START = 5'd3;
    localparam logic [OP_W-1:0] OP_SCAN       = 5'd4;
    localparam logic [OP_W-1:0] OP_ALLOC      = 5'd5;
    localparam logic [OP_W-1:0] OP_LINK_SELF  = 5'd6;
    localparam logic [OP_W-1:0] OP_PRE_LINK   = 5'd7;
    localparam logic [OP_W-1:0] OP_PRE_FIX    = 5'd8;
    localparam logic [OP_W-1:0] OP_APP_LINK   = 5'd9;
    localparam logic [OP_W-1:0] OP_APP_FIX    = 5'd10;
    localparam logic [OP_W-1:0] OP_RD_USED    = 5'd11;
    localparam logic [OP_W-1:0] OP_EMPTY      = 5'd12;
    localparam logic [OP_W-1:0] OP_WALK_START = 5'd13;
    localparam logic [OP_W-1:0] OP_WALK_STEP  = 5'd14;
    localparam logic [OP_W-1:0] OP_EHEAD      = 5'd15;
    localparam logic [OP_W-1:0] OP_ETAIL      = 5'd16;
    localparam logic [OP_W-1:0] OP_RD_LINK_H  = 5'd17;
    localparam logic [OP_W-1:0] OP_EMID       = 5'd18;
    localparam logic [OP_W-1:0] OP_RD_VAL     = 5'd19;
    localparam logic [OP_W-1:0] OP_RESULT     = 5'd20;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic                res_we;
        logic [STATUS_W-1:0] res_code;
    } cll_ctl_t;

    typedef struct packed {
        logic clr_last;
        logic is_insert;
        logic is_prepend;
        logic is_erase;
        logic full;
        logic handle_bad;
        logic free_found;
        logic used_hit;
        logic is_empty;
        logic single;
        logic h_is_head;
        logic h_is_tail;
        logic walk_hit;
    } cll_sts_t;

endpackage

[sv/cll_req_if.sv]
// Request channel: valid/ready plus command, value and handle.
// Depends on cll_pkg.
interface cll_req_if
    import cll_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] value;
    logic [HANDLE_W-1:0]      handle;

    modport source (output valid, cmd, value, handle, input ready);
    modport sink   (input valid, cmd, value, handle, output ready);
endinterface

[sv/cll_rsp_if.sv]
// Result channel: valid/ready plus status, count and head/tail report.
// Depends on cll_pkg.
interface cll_rsp_if
    import cll_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic [HANDLE_W-1:0]      new_handle;
    logic [COUNT_W-1:0]       count;
    logic                     empty_res;
    logic signed [DATA_W-1:0] head_value;
    logic signed [DATA_W-1:0] tail_value;
    logic [HANDLE_W-1:0]      head_handle;
    logic [HANDLE_W-1:0]      tail_handle;

    modport source (output valid, status, new_handle, count, empty_res, head_value,
                    tail_value, head_handle, tail_handle, input ready);
    modport sink   (input valid, status, new_handle, count, empty_res, head_value,
                    tail_value, head_handle, tail_handle, output ready);
endinterface

[sv/cll_dp.sv]
// Datapath: node value/link/used memories, list pointers and result register.
// Depends on cll_pkg; driven by cll_ctrl through cll_ctl_t.
module cll_dp
    import cll_pkg::*;
#(
    parameter int POOL_SIZE  = DEF_POOL_SIZE,
    parameter int VALUE_BITS = DEF_VALUE_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cll_ctl_t                 ctl,
    output cll_sts_t                 sts,
    input  logic [CMD_W-1:0]         cmd,
    input  logic signed [DATA_W-1:0] value,
    input  logic [HANDLE_W-1:0]      handle,
    output logic [STATUS_W-1:0]      status,
    output logic [HANDLE_W-1:0]      new_handle,
    output logic [COUNT_W-1:0]       count,
    output logic                     empty_res,
    output logic signed [DATA_W-1:0] head_value,
    output logic signed [DATA_W-1:0] tail_value,
    output logic [HANDLE_W-1:0]      head_handle,
    output logic [HANDLE_W-1:0]      tail_handle
);

    localparam int IDX_W = $clog2(POOL_SIZE);
    localparam int CNT_W = $clog2(POOL_SIZE + 1);

    typedef logic [IDX_W-1:0] idx_t;

    // Memories
    logic [VALUE_BITS-1:0] val_mem  [POOL_SIZE];
    idx_t                  link_mem [POOL_SIZE];
    logic                  used_mem [POOL_SIZE];

    // List state
    idx_t             head_reg, head_next;
    idx_t             tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    idx_t             scan_reg, scan_next;
    logic             scan_v_reg, scan_v_next;
    idx_t             p_reg, p_next;

    // Current item
    logic [CMD_W-1:0]      cmd_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic [HANDLE_W-1:0]   handle_reg;
    logic [STATUS_W-1:0]   stat_reg;
    idx_t                  newh_reg;
    idx_t                  slot_reg;

    // Read data
    logic                         used_q;
    idx_t                         used_addr_q;
    idx_t                         link_q;
    logic signed [VALUE_BITS-1:0] hv_q;
    logic signed [VALUE_BITS-1:0] tv_q;

    // Result register
    logic [STATUS_W-1:0]      status_reg;
    logic [HANDLE_W-1:0]      new_handle_reg;
    logic [COUNT_W-1:0]       count_out_reg;
    logic                     empty_reg;
    logic signed [DATA_W-1:0] head_value_reg;
    logic signed [DATA_W-1:0] tail_value_reg;
    logic [HANDLE_W-1:0]      head_handle_reg;
    logic [HANDLE_W-1:0]      tail_handle_reg;

    // Memory port controls
    logic used_we, used_wdata, used_re;
    idx_t used_waddr, used_raddr;
    logic link_we, link_re;
    idx_t link_waddr, link_wdata, link_raddr;
    logic val_we, val_re;

    logic [31:0] h_wide, cnt_wide, nh_wide, hh_wide, th_wide;
    logic [63:0] in_wide, hv_wide, tv_wide;
    idx_t        h_idx, scan_wrap;
    logic        list_empty;

    assign h_wide     = 32'(handle_reg);
    assign h_idx      = h_wide[IDX_W-1:0];
    assign in_wide    = 64'(value);
    assign scan_wrap  = (scan_reg == idx_t'(POOL_SIZE - 1)) ? '0 : scan_reg + idx_t'(1);
    assign list_empty = (count_reg == '0);

    assign cnt_wide = 32'(count_reg);
    assign nh_wide  = 32'(newh_reg);
    assign hh_wide  = 32'(head_reg);
    assign th_wide  = 32'(tail_reg);
    assign hv_wide  = 64'(hv_q);
    assign tv_wide  = 64'(tv_q);

    always_comb
    begin
        sts.clr_last   = (scan_reg == idx_t'(POOL_SIZE - 1));
        sts.is_insert  = (cmd_reg == CMD_PREPEND) || (cmd_reg == CMD_APPEND);
        sts.is_prepend = (cmd_reg == CMD_PREPEND);
        sts.is_erase   = (cmd_reg == CMD_ERASE);
        sts.full       = (cnt_wide >= 32'(POOL_SIZE));
        sts.handle_bad = (h_wide >= 32'(POOL_SIZE));
        sts.free_found = scan_v_reg && !used_q;
        sts.used_hit   = used_q;
        sts.is_empty   = list_empty;
        sts.single     = (count_reg == CNT_W'(1));
        sts.h_is_head  = (h_idx == head_reg);
        sts.h_is_tail  = (h_idx == tail_reg);
        sts.walk_hit   = (link_q == h_idx);
    end

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        scan_next   = scan_reg;
        scan_v_next = scan_v_reg;
        p_next      = p_reg;
        used_we     = 1'b0;
        used_waddr  = h_idx;
        used_wdata  = 1'b0;
        used_re     = 1'b0;
        used_raddr  = scan_reg;
        link_we     = 1'b0;
        link_waddr  = slot_reg;
        link_wdata  = head_reg;
        link_re     = 1'b0;
        link_raddr  = head_reg;
        val_we      = 1'b0;
        val_re      = 1'b0;
        unique case (ctl.op)
            OP_CLEAR:
            begin
                used_we    = 1'b1;
                used_waddr = scan_reg;
                scan_next  = scan_wrap;
            end
            OP_SCAN_START:
            begin
                scan_next   = '0;
                scan_v_next = 1'b0;
            end
            OP_SCAN:
            begin
                used_re     = 1'b1;
                used_raddr  = scan_reg;
                scan_next   = scan_wrap;
                scan_v_next = 1'b1;
            end
            OP_ALLOC:
            begin
                used_we     = 1'b1;
                used_waddr  = used_addr_q;
                used_wdata  = 1'b1;
                val_we      = 1'b1;
                scan_v_next = 1'b0;
            end
            OP_LINK_SELF:
            begin
                link_we    = 1'b1;
                link_wdata = slot_reg;
                head_next  = slot_reg;
                tail_next  = slot_reg;
                count_next = count_reg + CNT_W'(1);
            end
            OP_PRE_LINK:
            begin
                link_we = 1'b1;
            end
            OP_PRE_FIX:
            begin
                link_we    = 1'b1;
                link_waddr = tail_reg;
                link_wdata = slot_reg;
                head_next  = slot_reg;
                count_next = count_reg + CNT_W'(1);
            end
            OP_APP_LINK:
            begin
                link_we    = 1'b1;
                link_waddr = tail_reg;
                link_wdata = slot_reg;
            end
            OP_APP_FIX:
            begin
                link_we    = 1'b1;
                tail_next  = slot_reg;
                count_next = count_reg + CNT_W'(1);
            end
            OP_RD_USED:
            begin
                used_re    = 1'b1;
                used_raddr = h_idx;
            end
            OP_EMPTY:
            begin
                used_we    = 1'b1;
                head_next  = '0;
                tail_next  = '0;
                count_next = count_reg - CNT_W'(1);
            end
            OP_WALK_START:
            begin
                link_re = 1'b1;
                p_next  = head_reg;
            end
            OP_WALK_STEP:
            begin
                link_re    = 1'b1;
                link_raddr = link_q;
                p_next     = link_q;
            end
            OP_EHEAD:
            begin
                link_we    = 1'b1;
                link_waddr = tail_reg;
                link_wdata = link_q;
                head_next  = link_q;
                used_we    = 1'b1;
                count_next = count_reg - CNT_W'(1);
            end
            OP_ETAIL:
            begin
                link_we    = 1'b1;
                link_waddr = p_reg;
                tail_next  = p_reg;
                used_we    = 1'b1;
                count_next = count_reg - CNT_W'(1);
            end
            OP_RD_LINK_H:
            begin
                link_re    = 1'b1;
                link_raddr = h_idx;
            end
            OP_EMID:
            begin
                link_we    = 1'b1;
                link_waddr = p_reg;
                link_wdata = link_q;
                used_we    = 1'b1;
                count_next = count_reg - CNT_W'(1);
            end
            OP_RD_VAL:
            begin
                val_re = 1'b1;
            end
            default:
            begin
                val_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            scan_reg   <= '0;
            scan_v_reg <= 1'b0;
        end
        else
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            scan_reg   <= scan_next;
            scan_v_reg <= scan_v_next;
        end
    end

    // Memories: one write port each, registered reads
    always_ff @(posedge clk)
    begin
        if (used_we)
            used_mem[used_waddr] <= used_wdata;
        if (used_re)
        begin
            used_q      <= used_mem[used_raddr];
            used_addr_q <= used_raddr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
            link_mem[link_waddr] <= link_wdata;
        if (link_re)
            link_q <= link_mem[link_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (val_we)
            val_mem[used_addr_q] <= value_reg;
        if (val_re)
        begin
            hv_q <= val_mem[head_reg];
            tv_q <= val_mem[tail_reg];
        end
    end

    // Item capture and per-item bookkeeping
    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
        if (ctl.op == OP_LOAD)
        begin
            cmd_reg    <= cmd;
            value_reg  <= in_wide[VALUE_BITS-1:0];
            handle_reg <= handle;
            stat_reg   <= ST_DONE;
            newh_reg   <= '0;
        end
        else
        begin
            if (ctl.res_we)
                stat_reg <= ctl.res_code;
            if (ctl.op == OP_ALLOC)
            begin
                newh_reg <= used_addr_q;
                slot_reg <= used_addr_q;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.op == OP_RESULT)
        begin
            status_reg      <= stat_reg;
            new_handle_reg  <= nh_wide[HANDLE_W-1:0];
            count_out_reg   <= cnt_wide[COUNT_W-1:0];
            empty_reg       <= list_empty;
            head_value_reg  <= list_empty ? '0 : hv_wide[DATA_W-1:0];
            tail_value_reg  <= list_empty ? '0 : tv_wide[DATA_W-1:0];
            head_handle_reg <= hh_wide[HANDLE_W-1:0];
            tail_handle_reg <= th_wide[HANDLE_W-1:0];
        end
    end

    assign status      = status_reg;
    assign new_handle  = new_handle_reg;
    assign count       = count_out_reg;
    assign empty_res   = empty_reg;
    assign head_value  = head_value_reg;
    assign tail_value  = tail_value_reg;
    assign head_handle = head_handle_reg;
    assign tail_handle = tail_handle_reg;

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_wide <= 32'(POOL_SIZE))
        else $error("element count beyond pool size");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (head_reg == '0) && (tail_reg == '0))
        else $error("empty list with nonzero head or tail");

    a_alloc_free: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.op == OP_ALLOC) |-> scan_v_reg && !used_q)
        else $error("allocation of a slot in use");
`endif

endmodule

[sv/cll_ctrl.sv]
// Controller FSM: handshake, clearing pass and command sequencing.
// Depends on cll_pkg; steers cll_dp through cll_ctl_t / cll_sts_t.
module cll_ctrl
    import cll_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    input  cll_sts_t sts,
    output cll_ctl_t ctl
);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DECODE = 4'd2;
    localparam logic [3:0] S_SCAN   = 4'd3;
    localparam logic [3:0] S_SELF   = 4'd4;
    localparam logic [3:0] S_PRE1   = 4'd5;
    localparam logic [3:0] S_PRE2   = 4'd6;
    localparam logic [3:0] S_APP1   = 4'd7;
    localparam logic [3:0] S_APP2   = 4'd8;
    localparam logic [3:0] S_CHK    = 4'd9;
    localparam logic [3:0] S_EHEAD  = 4'd10;
    localparam logic [3:0] S_WALK   = 4'd11;
    localparam logic [3:0] S_EMID   = 4'd12;
    localparam logic [3:0] S_RDV    = 4'd13;
    localparam logic [3:0] S_OUT    = 4'd14;

    logic [3:0] state_reg, state_next;
    logic       rsp_valid_reg, rsp_valid_next;
    logic       req_fire;

    assign req_ready = (state_reg == S_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        ctl.op       = OP_NONE;
        ctl.res_we   = 1'b0;
        ctl.res_code = ST_DONE;
        unique case (state_reg)
            S_CLEAR:
            begin
                ctl.op = OP_CLEAR;
                if (sts.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    ctl.op     = OP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                priority if (sts.is_insert && sts.full)
                begin
                    ctl.res_we   = 1'b1;
                    ctl.res_code = ST_FULL;
                    state_next   = S_RDV;
                end
                else if (sts.is_insert)
                begin
                    ctl.op     = OP_SCAN_START;
                    state_next = S_SCAN;
                end
                else if (sts.is_erase && sts.handle_bad)
                begin
                    ctl.res_we   = 1'b1;
                    ctl.res_code = ST_NO_HANDLE;
                    state_next   = S_RDV;
                end
                else if (sts.is_erase)
                begin
                    ctl.op     = OP_RD_USED;
                    state_next = S_CHK;
                end
                else
                begin
                    state_next = S_RDV;
                end
            end
            S_SCAN:
            begin
                if (sts.free_found)
                begin
                    ctl.op = OP_ALLOC;
                    priority if (sts.is_empty)
                        state_next = S_SELF;
                    else if (sts.is_prepend)
                        state_next = S_PRE1;
                    else
                        state_next = S_APP1;
                end
                else
                begin
                    ctl.op = OP_SCAN;
                end
            end
            S_SELF:
            begin
                ctl.op     = OP_LINK_SELF;
                state_next = S_RDV;
            end
            S_PRE1:
            begin
                ctl.op     = OP_PRE_LINK;
                state_next = S_PRE2;
            end
            S_PRE2:
            begin
                ctl.op     = OP_PRE_FIX;
                state_next = S_RDV;
            end
            S_APP1:
            begin
                ctl.op     = OP_APP_LINK;
                state_next = S_APP2;
            end
            S_APP2:
            begin
                ctl.op     = OP_APP_FIX;
                state_next = S_RDV;
            end
            S_CHK:
            begin
                priority if (!sts.used_hit)
                begin
                    ctl.res_we   = 1'b1;
                    ctl.res_code = ST_NO_HANDLE;
                    state_next   = S_RDV;
                end
                else if (sts.single)
                begin
                    ctl.op     = OP_EMPTY;
                    state_next = S_RDV;
                end
                else if (sts.h_is_head)
                begin
                    ctl.op     = OP_WALK_START;
                    state_next = S_EHEAD;
                end
                else
                begin
                    ctl.op     = OP_WALK_START;
                    state_next = S_WALK;
                end
            end
            S_EHEAD:
            begin
                ctl.op     = OP_EHEAD;
                state_next = S_RDV;
            end
            S_WALK:
            begin
                priority if (sts.walk_hit && sts.h_is_tail)
                begin
                    ctl.op     = OP_ETAIL;
                    state_next = S_RDV;
                end
                else if (sts.walk_hit)
                begin
                    ctl.op     = OP_RD_LINK_H;
                    state_next = S_EMID;
                end
                else
                begin
                    ctl.op = OP_WALK_STEP;
                end
            end
            S_EMID:
            begin
                ctl.op     = OP_EMID;
                state_next = S_RDV;
            end
            S_RDV:
            begin
                ctl.op     = OP_RD_VAL;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    ctl.op     = OP_RESULT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (ctl.op == OP_RESULT)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

`ifndef ASSERT_OFF
    a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (state_reg == S_DECODE))
        else $error("accepted transfer not decoded");

    a_result_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.op == OP_RESULT) |-> (!rsp_valid_reg || rsp_ready))
        else $error("result overwrites a pending transfer");
`endif

endmodule

[sv/circular_linked_list_manager.sv]
// Top level of the circular linked list manager: controller plus datapath.
// Depends on cll_pkg, cll_req_if, cll_rsp_if, cll_ctrl, cll_dp.
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+-------------------------------------------
//   request  | in  | valid / ready | cmd, value, handle
//   result   | out | valid / ready | status, new_handle, count, empty_res,
//            |     |               | head_value, tail_value, head/tail_handle
//
// Sequencing: one item at a time. Prepend or append scans the used bitmap from
//   slot 0, one slot per cycle, and takes the lowest free slot. Erase of the
//   sole node or of the head needs no walk; erase of the tail or of a middle node
//   walks the links from the head, one link read per walk step, to the node's
//   predecessor. A full pool, an unused command code or an unknown handle gives
//   a result without a list change.
// Reset: a clearing pass over every slot wipes the used bitmap; request.ready
//   stays low until it ends.
// Stalls: a finished result sits in the result register; the next request is
//   taken meanwhile and only the following result waits for result.ready.
module circular_linked_list_manager
    import cll_pkg::*;
#(
    parameter int POOL_SIZE  = DEF_POOL_SIZE,
    parameter int VALUE_BITS = DEF_VALUE_BITS
)
(
    input logic      clk,
    input logic      rst_n,
    cll_req_if.sink  request,
    cll_rsp_if.source result
);

    cll_ctl_t ctl;
    cll_sts_t sts;

    // Sequencing and handshake
    cll_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .req_ready (request.ready),
        .rsp_valid (result.valid),
        .rsp_ready (result.ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    // Node pool, list pointers and result register
    cll_dp #(
        .POOL_SIZE  (POOL_SIZE),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .sts         (sts),
        .cmd         (request.cmd),
        .value       (request.value),
        .handle      (request.handle),
        .status      (result.status),
        .new_handle  (result.new_handle),
        .count       (result.count),
        .empty_res   (result.empty_res),
        .head_value  (result.head_value),
        .tail_value  (result.tail_value),
        .head_handle (result.head_handle),
        .tail_handle (result.tail_handle)
    );

endmodule
